// ----- sv/sar_pkg.sv -----
// Shared types and constants of the servo angle ramp block.
package sar_pkg;

   // Field widths
   localparam int ANGLE_W = 10;
   localparam int PW_W    = 14;
   localparam int STEP_W  = 14;
   localparam int DIV_W   = 13;   // magnitude of 8*(new - previous) angle

   // Pulse width mapping: 360 + 8*angle, saturated at 8352
   localparam logic [PW_W-1:0] WIDTH_BASE = 14'd360;
   localparam logic [PW_W-1:0] WIDTH_MAX  = 14'd8352;

   // Character offsets within one six-character group
   localparam logic [2:0] OFF_FIRST_DIGIT = 3'd3;
   localparam logic [2:0] OFF_LAST        = 3'd5;

   // Command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // One joint's stored record
   typedef struct packed {
      logic [ANGLE_W-1:0]       prev_angle;
      logic [PW_W-1:0]          width;
      logic signed [STEP_W-1:0] step;
   } joint_rec_type;

   // Group-closing event from the message parser
   typedef struct packed {
      logic               done;
      logic               last;
      logic [ANGLE_W-1:0] angle;
   } grp_event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BYTE_RD,
      ST_BYTE_CALC,
      ST_BYTE_DIV,
      ST_TICK_RD,
      ST_TICK_CALC
   } sar_state_type;

endpackage

// ----- sv/sar_joint_mem.sv -----
// Per-joint record memory: one write port, one registered read port, reset-clear valid bits.
module sar_joint_mem #(
   parameter int DEPTH = 6,
   parameter int AW    = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output sar_pkg::joint_rec_type rd_data,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  sar_pkg::joint_rec_type wr_data
);

   sar_pkg::joint_rec_type mem_ff [DEPTH];
   sar_pkg::joint_rec_type rd_data_ff;
   logic [DEPTH-1:0]       valid_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // entry valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read; an unwritten entry reads as all zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sar_step_div.sv -----
// Signed division of the scaled angle difference by the ramp step count, with a registered result.
module sar_step_div #(
   parameter int RAMP_STEPS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                neg,
   input  logic [sar_pkg::DIV_W-1:0]           mag,
   output logic                                done,
   output logic signed [sar_pkg::STEP_W-1:0]   quot
);

   // floor(mag / RAMP_STEPS) as (mag * RECIP) >> RECIP_SH; the rounding error
   // of RECIP times the largest magnitude stays below 2^RECIP_SH, so it is exact
   localparam int RECIP_SH = sar_pkg::DIV_W + 5;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam int PROD_W   = sar_pkg::DIV_W + RECIP_SH;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << RECIP_SH) + RAMP_STEPS - 1) / RAMP_STEPS);

   logic                              done_ff;
   logic signed [sar_pkg::STEP_W-1:0] quot_ff;
   logic [PROD_W-1:0]                 prod;
   logic [sar_pkg::DIV_W-1:0]         q_mag;
   logic [sar_pkg::STEP_W-1:0]        q_ext;

   // reciprocal multiply of the magnitude
   assign prod  = PROD_W'(mag) * PROD_W'(RECIP);
   assign q_mag = prod[PROD_W-1:RECIP_SH];
   assign q_ext = {1'b0, q_mag};

   // result is ready the cycle after start
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // truncation toward zero: divide the magnitude, then restore the sign
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= neg ? $signed(-q_ext) : $signed(q_ext);
      end
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

// ----- sv/sar_msg_parse.sv -----
// Message parser: group and character counters and the decimal angle accumulator.
module sar_msg_parse #(
   parameter int JOINTS = 6,
   parameter int JIDX_W = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_en,
   input  logic [7:0]             data_byte,
   output logic [JIDX_W-1:0]      grp_idx,
   output sar_pkg::grp_event_type grp_evt
);

   localparam logic [JIDX_W-1:0] LAST_GRP = JIDX_W'(JOINTS - 1);

   logic [2:0]                    offset_ff;
   logic [JIDX_W-1:0]             grp_ff;
   logic [sar_pkg::ANGLE_W-1:0]   digits_ff;
   logic [3:0]                    digit;
   logic [13:0]                   acc;

   function automatic logic [3:0] digit_of(input logic [7:0] ch);
      logic [7:0] d;
      d = ch - 8'h30;
      if (ch >= 8'h31 && ch <= 8'h39) begin
         return d[3:0];
      end
      return 4'd0;
   endfunction

   // digits*10 + new digit; with three digits per group this stays below 1000
   assign digit = digit_of(data_byte);
   assign acc   = 14'({digits_ff, 3'b000}) + 14'({digits_ff, 1'b0}) + 14'(digit);

   assign grp_idx       = grp_ff;
   assign grp_evt.done  = (offset_ff == sar_pkg::OFF_LAST);
   assign grp_evt.last  = (grp_ff == LAST_GRP);
   assign grp_evt.angle = acc[sar_pkg::ANGLE_W-1:0];

   // counters and accumulator advance on every message byte
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         grp_ff    <= '0;
         digits_ff <= '0;
      end else if (byte_en) begin
         if (offset_ff < sar_pkg::OFF_FIRST_DIGIT) begin
            digits_ff <= '0;
         end else if (offset_ff < sar_pkg::OFF_LAST) begin
            digits_ff <= acc[sar_pkg::ANGLE_W-1:0];
         end else begin
            digits_ff <= '0;
         end
         if (offset_ff == sar_pkg::OFF_LAST) begin
            offset_ff <= '0;
            grp_ff    <= (grp_ff == LAST_GRP) ? '0 : grp_ff + 1'b1;
         end else begin
            offset_ff <= offset_ff + 1'b1;
         end
      end
   end

endmodule

// ----- sv/servo_angle_ramp.sv -----
// Servo angle ramp controller: top level with sequencer and result register.
//
// Takes a message of JOINTS groups of six ASCII characters; the last three
// characters of a group are a joint's new angle (non-digits count as 0).
// A group sets the joint's pulse width to 360 + 8*previous angle and its
// step to (8*new - 8*previous)/RAMP_STEPS truncated toward zero; a complete
// message arms RAMP_STEPS ticks, and each armed tick adds the steps (with
// saturation at 0 and 8352) and returns one word per joint, the last one
// flagged. Joint records live in a one-read, one-write memory with a
// registered read, and every access is sequenced so reads and writes of the
// same record never overlap. Sequence: a byte inside a group is accepted
// with no further work; a group-closing byte is accepted, then the record
// is read, the step computed by reciprocal multiplication and the record
// written back; an armed tick is accepted, then each joint in turn is read
// and updated, the update waiting while the result register waits on
// rsp_ready; an unarmed tick is only accepted.
module servo_angle_ramp #(
   parameter int JOINTS     = 6,
   parameter int RAMP_STEPS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_joint,
   output logic [13:0] rsp_pulse_width,
   output logic        rsp_last
);

   localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int TICK_W = $clog2(RAMP_STEPS + 1);
   localparam logic [JIDX_W-1:0] LAST_J     = JIDX_W'(JOINTS - 1);
   localparam logic [TICK_W-1:0] TICKS_FULL = TICK_W'(RAMP_STEPS);

   sar_pkg::sar_state_type state_ff, state_in;
   logic [JIDX_W-1:0]            joint_ff, joint_in;
   logic [JIDX_W-1:0]            grp_ff, grp_in;
   logic [sar_pkg::ANGLE_W-1:0]  angle_ff, angle_in;
   logic                         last_grp_ff, last_grp_in;
   logic [TICK_W-1:0]            ticks_ff, ticks_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   rsp_joint_ff, rsp_joint_in;
   logic [sar_pkg::PW_W-1:0]     rsp_pw_ff, rsp_pw_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         accept;
   logic                         byte_en;
   logic [JIDX_W-1:0]            parse_grp;
   sar_pkg::grp_event_type       parse_evt;

   logic                         rd_en;
   logic [JIDX_W-1:0]            rd_addr;
   sar_pkg::joint_rec_type       rd_data;
   logic                         wr_en;
   logic [JIDX_W-1:0]            wr_addr;
   sar_pkg::joint_rec_type       wr_data;

   logic                               div_start;
   logic                               div_done;
   logic [sar_pkg::DIV_W-1:0]          div_mag;
   logic signed [sar_pkg::STEP_W-1:0]  div_quot;
   logic [10:0]                        diff;
   logic [10:0]                        diff_abs;
   logic [sar_pkg::PW_W-1:0]           start_w;
   logic signed [15:0]                 sum;
   logic [sar_pkg::PW_W-1:0]           new_w;
   logic [JIDX_W+2:0]                  joint_ext;

   assign req_ready = (state_ff == sar_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign byte_en   = accept && (req_command == sar_pkg::CMD_BYTE);

   sar_msg_parse #(
      .JOINTS (JOINTS),
      .JIDX_W (JIDX_W)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .data_byte (req_data_byte),
      .grp_idx   (parse_grp),
      .grp_evt   (parse_evt)
   );

   sar_joint_mem #(
      .DEPTH (JOINTS),
      .AW    (JIDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   sar_step_div #(
      .RAMP_STEPS (RAMP_STEPS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .neg   (diff[10]),
      .mag   (div_mag),
      .done  (div_done),
      .quot  (div_quot)
   );

   // group update: 8*(new - previous) split into sign and magnitude
   assign diff     = {1'b0, angle_ff} - {1'b0, rd_data.prev_angle};
   assign diff_abs = diff[10] ? (11'd0 - diff) : diff;
   assign div_mag  = {diff_abs[9:0], 3'b000};
   assign start_w  = sar_pkg::WIDTH_BASE + {1'b0, rd_data.prev_angle, 3'b000};

   // tick update: width plus signed step, clamped
   assign sum = $signed({2'b00, rd_data.width}) + 16'(rd_data.step);
   always_comb begin
      if (sum < 0) begin
         new_w = '0;
      end else if (sum > $signed({2'b00, sar_pkg::WIDTH_MAX})) begin
         new_w = sar_pkg::WIDTH_MAX;
      end else begin
         new_w = sum[sar_pkg::PW_W-1:0];
      end
   end

   assign joint_ext = {3'b000, joint_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      joint_in     = joint_ff;
      grp_in       = grp_ff;
      angle_in     = angle_ff;
      last_grp_in  = last_grp_ff;
      ticks_in     = ticks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_joint_in = rsp_joint_ff;
      rsp_pw_in    = rsp_pw_ff;
      rsp_last_in  = rsp_last_ff;
      rd_en        = 1'b0;
      rd_addr      = joint_ff;
      wr_en        = 1'b0;
      wr_addr      = joint_ff;
      wr_data      = rd_data;
      div_start    = 1'b0;
      unique case (state_ff)
         sar_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == sar_pkg::CMD_BYTE) begin
                  if (parse_evt.done) begin
                     grp_in      = parse_grp;
                     angle_in    = parse_evt.angle;
                     last_grp_in = parse_evt.last;
                     state_in    = sar_pkg::ST_BYTE_RD;
                  end
               end else if (ticks_ff != '0) begin
                  ticks_in = ticks_ff - 1'b1;
                  joint_in = '0;
                  state_in = sar_pkg::ST_TICK_RD;
               end
            end
         end
         sar_pkg::ST_BYTE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = grp_ff;
            state_in = sar_pkg::ST_BYTE_CALC;
         end
         sar_pkg::ST_BYTE_CALC: begin
            div_start = 1'b1;
            state_in  = sar_pkg::ST_BYTE_DIV;
         end
         sar_pkg::ST_BYTE_DIV: begin
            // read data holds: no read is issued while dividing
            if (div_done) begin
               wr_en              = 1'b1;
               wr_addr            = grp_ff;
               wr_data.prev_angle = angle_ff;
               wr_data.width      = start_w;
               wr_data.step       = div_quot;
               if (last_grp_ff) begin
                  ticks_in = TICKS_FULL;
               end
               state_in = sar_pkg::ST_IDLE;
            end
         end
         sar_pkg::ST_TICK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = joint_ff;
            state_in = sar_pkg::ST_TICK_CALC;
         end
         sar_pkg::ST_TICK_CALC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               wr_en         = 1'b1;
               wr_addr       = joint_ff;
               wr_data.width = new_w;
               rsp_valid_in  = 1'b1;
               rsp_joint_in  = joint_ext[2:0];
               rsp_pw_in     = new_w;
               rsp_last_in   = (joint_ff == LAST_J);
               if (joint_ff == LAST_J) begin
                  state_in = sar_pkg::ST_IDLE;
               end else begin
                  joint_in = joint_ff + 1'b1;
                  state_in = sar_pkg::ST_TICK_RD;
               end
            end
         end
         default: begin
            state_in = sar_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sar_pkg::ST_IDLE;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      joint_ff     <= joint_in;
      grp_ff       <= grp_in;
      angle_ff     <= angle_in;
      last_grp_ff  <= last_grp_in;
      rsp_joint_ff <= rsp_joint_in;
      rsp_pw_ff    <= rsp_pw_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_joint       = rsp_joint_ff;
   assign rsp_pulse_width = rsp_pw_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   // armed tick count never exceeds a full ramp
   a_ticks_range: assert property (@(posedge clock) disable iff (reset)
      ticks_ff <= TICKS_FULL)
      else $error("ticks_left above ramp length");

   // the flagged word belongs to the final joint
   a_last_joint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_joint == 3'(JOINTS - 1))
      else $error("last flag on wrong joint");

   // pulse widths stay clamped
   a_pw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pulse_width <= sar_pkg::WIDTH_MAX)
      else $error("pulse width out of range");

   // an unarmed tick leaves everything alone
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == sar_pkg::CMD_TICK && ticks_ff == '0
      |=> state_ff == sar_pkg::ST_IDLE && $stable(ticks_ff))
      else $error("unarmed tick changed state");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == sar_pkg::ST_BYTE_DIV)
      else $error("divider result outside group update");
`endif

endmodule

// ----- tb/sv/sar_pulse_checker.sv -----
// Pulse-width predictor and word checker for the servo angle ramp testbench.
`timescale 1ns / 1ps

module sar_pulse_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_joint,
   input  logic [13:0] rsp_pulse_width,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
);

   localparam int JOINTS     = 6;
   localparam int RAMP_STEPS = 8;
   localparam int GROUP_LEN  = 6;
   localparam int MSG_LEN    = JOINTS * GROUP_LEN;

   typedef struct packed {
      logic [2:0]               joint;
      logic [sar_pkg::PW_W-1:0] width;
      logic                     last;
   } pulse_word_type;

   // Expected words, oldest first
   pulse_word_type pulse_due[$];

   // Predicted block state
   int unsigned                        msg_pos;
   int unsigned                        angle_acc;
   int unsigned                        ramp_left;
   logic [sar_pkg::ANGLE_W-1:0]        prev_angle [JOINTS];
   logic [sar_pkg::PW_W-1:0]           width_now  [JOINTS];
   logic signed [sar_pkg::STEP_W-1:0]  step_now   [JOINTS];

   function automatic int unsigned char_digit(logic [7:0] ch);
      return (ch >= "1" && ch <= "9") ? int'(ch) - int'("0") : 0;
   endfunction

   // Message byte: gather angle digits, close a group on its sixth char
   function automatic void absorb_char(logic [7:0] ch);
      int unsigned grp;
      int unsigned off;
      int unsigned angle;
      int          start_w;
      int          goal_w;
      grp = msg_pos / GROUP_LEN;
      off = msg_pos % GROUP_LEN;
      if (grp >= JOINTS) begin
         msg_pos   = 0;
         angle_acc = 0;
         return;
      end
      if (off < sar_pkg::OFF_FIRST_DIGIT) begin
         angle_acc = 0;
      end else if (off < sar_pkg::OFF_LAST) begin
         angle_acc = (angle_acc * 10 + char_digit(ch)) % 1000;
      end else begin
         angle           = (angle_acc * 10 + char_digit(ch)) % 1000;
         start_w         = int'(sar_pkg::WIDTH_BASE) + 8 * int'(prev_angle[grp]);
         goal_w          = int'(sar_pkg::WIDTH_BASE) + 8 * int'(angle);
         width_now[grp]  = sar_pkg::PW_W'(start_w);
         step_now[grp]   = sar_pkg::STEP_W'((goal_w - start_w) / RAMP_STEPS);
         prev_angle[grp] = sar_pkg::ANGLE_W'(angle);
         angle_acc       = 0;
      end
      msg_pos++;
      if (msg_pos >= MSG_LEN) begin
         msg_pos   = 0;
         ramp_left = RAMP_STEPS;
      end
   endfunction

   // Ramp tick: step every joint with saturation, one word per joint
   function automatic void advance_ramp();
      int             w;
      pulse_word_type word;
      if (ramp_left == 0)
         return;
      ramp_left--;
      for (int k = 0; k < JOINTS; k++) begin
         w = int'(width_now[k]) + int'(step_now[k]);
         if (w < 0)
            w = 0;
         if (w > int'(sar_pkg::WIDTH_MAX))
            w = int'(sar_pkg::WIDTH_MAX);
         width_now[k] = sar_pkg::PW_W'(w);
         word.joint   = 3'(k);
         word.width   = sar_pkg::PW_W'(w);
         word.last    = (k == JOINTS - 1);
         pulse_due.push_back(word);
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Compare words first, then fold in the accepted input word
   always @(posedge clock) begin
      pulse_word_type due;
      if (reset) begin
         msg_pos    = 0;
         angle_acc  = 0;
         ramp_left  = 0;
         fail_count = 0;
         for (int k = 0; k < JOINTS; k++) begin
            prev_angle[k] = '0;
            width_now[k]  = '0;
            step_now[k]   = '0;
         end
         pulse_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pulse_due.size() == 0) begin
               report_mismatch("unexpected word, pulse_width", int'(rsp_pulse_width), -1);
            end else begin
               due = pulse_due.pop_front();
               if (rsp_joint !== due.joint)
                  report_mismatch("joint", int'(rsp_joint), int'(due.joint));
               if (rsp_pulse_width !== due.width)
                  report_mismatch("pulse_width", int'(rsp_pulse_width), int'(due.width));
               if (rsp_last !== due.last)
                  report_mismatch("last", int'(rsp_last), int'(due.last));
            end
         end
         if (req_valid && req_ready) begin
            if (req_command == sar_pkg::CMD_TICK)
               advance_ramp();
            else
               absorb_char(req_data_byte);
         end
      end
      pending = pulse_due.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the servo angle ramp testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

   localparam int GROUPS         = 6;
   localparam int MSG_BYTES      = 36;
   localparam int TARGET_ITEMS   = 500;
   localparam int CALM_AFTER     = 440;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 40;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_command;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_joint;
   logic [13:0] rsp_pulse_width;
   logic        rsp_last;

   int fails;
   int pending;
   int sent;
   int msg_fill;
   int quiet_cycles;
   bit calm;
   bit stall_rsp;

   servo_angle_ramp uut (.*);

   sar_pulse_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_command, .req_data_byte,
      .rsp_valid, .rsp_ready, .rsp_joint, .rsp_pulse_width, .rsp_last,
      .fail_count(fails), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: too long with no word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: random short stalls, one long hold on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_rsp) begin
            stall_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One input word; returns at the edge where it is taken
   task automatic send_word(input logic cmd, input logic [7:0] data);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= data;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sent++;
      if (cmd == sar_pkg::CMD_BYTE)
         msg_fill = (msg_fill + 1) % MSG_BYTES;
   endtask

   // Six characters, first one in the top byte
   task automatic send_group_raw(input logic [47:0] chars);
      for (int i = 0; i < 6; i++)
         send_word(sar_pkg::CMD_BYTE, chars[47 - 8 * i -: 8]);
   endtask

   // Random ignored prefix, then the angle as three digits (maybe garbled)
   task automatic send_group(input int unsigned angle, input bit noisy);
      logic [47:0] chars;
      chars[47:24] = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255))};
      chars[23:16] = 8'("0" + angle / 100);
      chars[15:8]  = 8'("0" + (angle / 10) % 10);
      chars[7:0]   = 8'("0" + angle % 10);
      for (int i = 0; i < 3; i++)
         if (noisy && $urandom_range(0, 5) == 0)
            chars[8 * i +: 8] = 8'($urandom_range(0, 255));
      send_group_raw(chars);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_word(sar_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
   endtask

   // Pad with random bytes up to a message boundary
   task automatic realign();
      while (msg_fill != 0)
         send_word(sar_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
   endtask

   // Stop offering until every expected word is back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned pick_angle();
      unique case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 999;
         default: return $urandom_range(0, 999);
      endcase
   endfunction

   initial begin
      int mode;
      int split;
      req_valid     <= 1'b0;
      req_command   <= sar_pkg::CMD_BYTE;
      req_data_byte <= 8'h00;
      reset         <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // tick with nothing armed
      send_word(sar_pkg::CMD_TICK, 8'hFF);

      // all joints 0 -> 999, extreme ignored chars
      repeat (GROUPS) send_group_raw({8'h00, 8'hFF, "5", "999"});

      // joint 0 back to 0 mid-message, ramp it on the old arming
      send_group_raw({"999", "000"});
      send_ticks(8);
      repeat (GROUPS - 1) send_group_raw({"123", "999"});
      // second arming keeps stepping joint 0 down: floor at zero, one extra tick
      send_ticks(9);

      // joint 0 up again to the top, one extra tick at the end
      send_group(999, 1'b0);
      send_ticks(8);
      send_group_raw({"000", ":/", 8'h00});
      send_group_raw({"7", 8'h80, 8'h7F, "0", "a", 8'hFF});
      repeat (GROUPS - 3) send_group(pick_angle(), 1'b0);
      send_ticks(9);
      drain();

      // long receiver hold while the sender keeps pushing
      stall_rsp = 1'b1;
      repeat (GROUPS) send_group(pick_angle(), 1'b1);
      send_ticks(8);
      drain();

      // random traffic, mostly whole messages with random content
      while (sent < TARGET_ITEMS) begin
         if (sent >= CALM_AFTER)
            calm = 1'b1;
         mode = $urandom_range(0, 19);
         if (mode < 12) begin
            split = (mode < 3) ? $urandom_range(1, GROUPS - 1) : GROUPS;
            for (int g = 0; g < split; g++)
               send_group(pick_angle(), 1'b1);
            if (split < GROUPS) begin
               send_ticks($urandom_range(0, 4));
               for (int g = split; g < GROUPS; g++)
                  send_group(pick_angle(), 1'b1);
            end
            send_ticks($urandom_range(0, 10));
         end else if (mode < 15) begin
            repeat ($urandom_range(1, 8))
               send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            realign();
         end else if (mode < 18) begin
            repeat ($urandom_range(1, GROUPS - 1)) send_group(pick_angle(), 1'b1);
            send_ticks($urandom_range(0, 3));
            realign();
         end else if (mode == 18 && !calm) begin
            drain();
         end else begin
            send_ticks($urandom_range(1, 10));
         end
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
